FILE: hdl/sei_pkg.sv
// shared types and constants for the sei nal encapsulator
package sei_pkg;

  localparam int MAX_PAYLOAD_DEFAULT = 1023;
  localparam int LEN_W               = 10;
  localparam int BYTE_W              = 8;
  localparam int MAX_RESULTS         = 12;
  localparam int COUNT_W             = $clog2(MAX_RESULTS + 1);
  localparam int CFG_INDEX_W         = 2;
  localparam int CFG_DATA_W          = 8;

  // item kinds
  localparam logic KIND_BEGIN = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CODEC_HEVC  = 2'd0,
    CFG_LAYER_BIT   = 2'd1,
    CFG_SECOND_BYTE = 2'd2
  } cfg_index_t;

  // framing byte values
  localparam logic [BYTE_W-1:0] BYTE_ZERO      = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_ONE       = 8'h01;
  localparam logic [BYTE_W-1:0] BYTE_ESCAPE    = 8'h03;
  localparam logic [BYTE_W-1:0] BYTE_FF        = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_TRAILING  = 8'h80;
  localparam logic [BYTE_W-1:0] BYTE_AVC_SEI   = 8'h06;
  localparam logic [BYTE_W-1:0] BYTE_PT_USER   = 8'd5;
  localparam logic [5:0]        HEVC_SEI_TYPE  = 6'd39;
  localparam logic [BYTE_W-1:0] SECOND_RESET   = 8'h01;

  // bytes for one accepted word, front first
  typedef struct packed {
    logic [MAX_RESULTS-1:0][BYTE_W-1:0] bytes;
    logic [COUNT_W-1:0]                 count;
    logic                               term;
  } result_list_t;

endpackage

FILE: hdl/sei_if.sv
// valid/ready channel interfaces for input items and output bytes
interface sei_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [sei_pkg::LEN_W-1:0]    payload_length;
  logic [sei_pkg::BYTE_W-1:0]   data_byte;

  modport source (output valid, output kind, output payload_length, output data_byte,
                  input ready);
  modport sink   (input valid, input kind, input payload_length, input data_byte,
                  output ready);
endinterface

interface sei_out_if;
  logic                         valid;
  logic                         ready;
  logic [sei_pkg::BYTE_W-1:0]   out_byte;
  logic                         last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

FILE: hdl/sei_nal_encapsulator.sv
// top level of the sei nal encapsulator
//
// in_ch takes words: a begin word (kind 0) with payload_length, or a data
// word (kind 1) with data_byte. out_ch gives the framed nal unit, one byte
// per word, with last set on the trailing 0x80.
// a begin word yields the start code, nal header, payload type, size bytes
// (and the trailing byte when the length is zero): 7 to 11 bytes.
// a data word yields 0 to 3 bytes (escape, payload, trailing byte).
// configuration goes through cfg_we/cfg_index/cfg_data; it is to be
// written only while idle, which the block itself does not enforce.
// the first byte of a word is on out_ch in the cycle after its accept.
// throughput: one output byte per cycle while out_ch is ready, set by
// the single output shift register; the next word is accepted in the
// cycle its predecessor's final byte leaves, so one data word a cycle
// goes through while out_ch is ready and no escape or trailing byte is
// inserted. data words yielding nothing wait for the queue like others.
// when out_ch stalls, the held byte stays and in_ch.ready drops once a
// word's list is waiting. reset clears the queue and framing state and
// restores the configuration defaults (h.264, second header byte 0x01).
module sei_nal_encapsulator #(
  parameter int MAX_PAYLOAD = sei_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sei_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sei_pkg::CFG_DATA_W-1:0]  cfg_data,
  sei_in_if.sink                          in_ch,
  sei_out_if.source                       out_ch
);

  sei_pkg::result_list_t list;
  logic                  load_ready;
  logic                  accept;

  // a word is taken whenever the queue is empty or its final byte leaves
  assign in_ch.ready = load_ready;
  assign accept      = in_ch.valid && load_ready;

  sei_framer #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_framer (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .accept         (accept),
    .kind           (in_ch.kind),
    .payload_length (in_ch.payload_length),
    .data_byte      (in_ch.data_byte),
    .list           (list)
  );

  sei_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .list       (list),
    .load_ready (load_ready),
    .out_ch     (out_ch)
  );

  // a begin word always frames at least header, type and size bytes
  a_begin_count: assert property (@(posedge clk) disable iff (rst)
    accept && (in_ch.kind == sei_pkg::KIND_BEGIN) |-> list.count >= sei_pkg::COUNT_W'(7))
    else $error("begin word framed too few bytes");

  // a data word yields at most escape, payload and trailing byte
  a_data_count: assert property (@(posedge clk) disable iff (rst)
    accept && (in_ch.kind == sei_pkg::KIND_DATA) |-> list.count <= sei_pkg::COUNT_W'(3))
    else $error("data word framed too many bytes");

  // a begin word puts bytes on the output in the next cycle
  a_begin_out: assert property (@(posedge clk) disable iff (rst)
    accept && (in_ch.kind == sei_pkg::KIND_BEGIN) |=> out_ch.valid)
    else $error("begin word produced no output");

  // input back-pressure only while bytes are waiting
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with empty queue");

endmodule

FILE: hdl/sei_framer.sv
// framing state, configuration registers and per-word byte list generation
module sei_framer #(
  parameter int MAX_PAYLOAD = sei_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sei_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sei_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             accept,
  input  logic                             kind,
  input  logic [sei_pkg::LEN_W-1:0]        payload_length,
  input  logic [sei_pkg::BYTE_W-1:0]       data_byte,
  output sei_pkg::result_list_t            list
);

  localparam logic [sei_pkg::LEN_W-1:0] MAX_LEN = sei_pkg::LEN_W'(MAX_PAYLOAD);
  localparam logic [sei_pkg::LEN_W-1:0] RUN     = sei_pkg::LEN_W'(255);

  logic                        codec_hevc;
  logic                        hevc_layer_bit;
  logic [sei_pkg::BYTE_W-1:0]  hevc_second_header_byte;

  logic [1:0]                  zero_run, zero_run_next;
  logic [sei_pkg::LEN_W-1:0]   bytes_remaining, bytes_remaining_next;
  logic                        message_open, message_open_next;

  logic [sei_pkg::LEN_W-1:0]   len_sat;
  logic [2:0]                  nff;
  logic [sei_pkg::LEN_W-1:0]   ff_sub;
  logic [sei_pkg::LEN_W-1:0]   rest_w;
  logic [sei_pkg::BYTE_W-1:0]  rest;
  logic                        zero_len;
  logic [2:0]                  pos;

  logic                        live;
  logic                        esc;
  logic [1:0]                  zr_esc;
  logic [sei_pkg::LEN_W-1:0]   rem_dec;
  logic                        fin;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      codec_hevc              <= 1'b0;
      hevc_layer_bit          <= 1'b0;
      hevc_second_header_byte <= sei_pkg::SECOND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sei_pkg::CFG_CODEC_HEVC:  codec_hevc              <= cfg_data[0];
        sei_pkg::CFG_LAYER_BIT:   hevc_layer_bit          <= cfg_data[0];
        sei_pkg::CFG_SECOND_BYTE: hevc_second_header_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  // size coding: a run of 0xff bytes and a remainder
  always_comb begin
    len_sat  = (payload_length > MAX_LEN) ? MAX_LEN : payload_length;
    nff      = 3'(len_sat >= RUN) + 3'(len_sat >= 2 * RUN) + 3'(len_sat >= 3 * RUN)
             + 3'(len_sat >= 4 * RUN);
    unique case (nff)
      3'd0:    ff_sub = '0;
      3'd1:    ff_sub = RUN;
      3'd2:    ff_sub = sei_pkg::LEN_W'(2 * RUN);
      3'd3:    ff_sub = sei_pkg::LEN_W'(3 * RUN);
      default: ff_sub = sei_pkg::LEN_W'(4 * RUN);
    endcase
    rest_w   = len_sat - ff_sub;
    rest     = rest_w[sei_pkg::BYTE_W-1:0];
    zero_len = (len_sat == '0);
  end

  // data word: escape and countdown
  always_comb begin
    live    = message_open && (bytes_remaining != '0);
    esc     = live && zero_run[1] && (data_byte <= sei_pkg::BYTE_ESCAPE);
    zr_esc  = esc ? 2'd0 : zero_run;
    rem_dec = bytes_remaining - 1'b1;
    fin     = live && (rem_dec == '0);
  end

  // byte list and next state
  always_comb begin
    list                 = '0;
    pos                  = '0;
    zero_run_next        = zero_run;
    bytes_remaining_next = bytes_remaining;
    message_open_next    = message_open;
    if (kind == sei_pkg::KIND_BEGIN) begin
      if (codec_hevc) begin
        list.bytes[0] = sei_pkg::BYTE_ZERO;
        list.bytes[1] = sei_pkg::BYTE_ZERO;
        list.bytes[2] = sei_pkg::BYTE_ONE;
        list.bytes[3] = {1'b0, sei_pkg::HEVC_SEI_TYPE, hevc_layer_bit};
        list.bytes[4] = hevc_second_header_byte;
      end else begin
        list.bytes[0] = sei_pkg::BYTE_ZERO;
        list.bytes[1] = sei_pkg::BYTE_ZERO;
        list.bytes[2] = sei_pkg::BYTE_ZERO;
        list.bytes[3] = sei_pkg::BYTE_ONE;
        list.bytes[4] = sei_pkg::BYTE_AVC_SEI;
      end
      list.bytes[5] = sei_pkg::BYTE_PT_USER;
      for (int i = 0; i < sei_pkg::MAX_RESULTS - 6; i++) begin
        pos = 3'(i);
        if (pos < nff) begin
          list.bytes[6+i] = sei_pkg::BYTE_FF;
        end else if (pos == nff) begin
          list.bytes[6+i] = rest;
        end else if ((pos == nff + 3'd1) && zero_len) begin
          list.bytes[6+i] = sei_pkg::BYTE_TRAILING;
        end
      end
      list.count           = sei_pkg::COUNT_W'(7) + sei_pkg::COUNT_W'(nff)
                           + sei_pkg::COUNT_W'(zero_len);
      list.term            = zero_len;
      zero_run_next        = (rest == '0) ? 2'd1 : 2'd0;
      bytes_remaining_next = zero_len ? '0 : len_sat;
      message_open_next    = !zero_len;
    end else if (!live) begin
      message_open_next = 1'b0;
    end else begin
      list.bytes[0] = esc ? sei_pkg::BYTE_ESCAPE : data_byte;
      list.bytes[1] = esc ? data_byte : sei_pkg::BYTE_TRAILING;
      list.bytes[2] = sei_pkg::BYTE_TRAILING;
      list.count    = sei_pkg::COUNT_W'(1) + sei_pkg::COUNT_W'(esc) + sei_pkg::COUNT_W'(fin);
      list.term     = fin;
      if (data_byte == '0) begin
        zero_run_next = zr_esc[1] ? zr_esc : zr_esc + 2'd1;
      end else begin
        zero_run_next = 2'd0;
      end
      bytes_remaining_next = rem_dec;
      if (fin) begin
        message_open_next = 1'b0;
        zero_run_next     = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run        <= '0;
      bytes_remaining <= '0;
      message_open    <= 1'b0;
    end else if (accept) begin
      zero_run        <= zero_run_next;
      bytes_remaining <= bytes_remaining_next;
      message_open    <= message_open_next;
    end
  end

endmodule

FILE: hdl/sei_out_queue.sv
// output shift register sending a word's bytes one per cycle while ready
module sei_out_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  sei_pkg::result_list_t list,
  output logic                  load_ready,
  sei_out_if.source             out_ch
);

  logic [sei_pkg::MAX_RESULTS-1:0][sei_pkg::BYTE_W-1:0] bytes;
  logic [sei_pkg::COUNT_W-1:0]                          count;
  logic                                                 term;
  logic                                                 take;

  assign take       = out_ch.valid && out_ch.ready;
  assign load_ready = (count == '0) || ((count == sei_pkg::COUNT_W'(1)) && out_ch.ready);

  assign out_ch.valid    = (count != '0);
  assign out_ch.out_byte = bytes[0];
  assign out_ch.last     = term && (count == sei_pkg::COUNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      term  <= 1'b0;
    end else if (load) begin
      count <= list.count;
      term  <= list.term;
    end else if (take) begin
      count <= count - 1'b1;
    end
  end

  // payload shifts toward the front
  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= list.bytes;
    end else if (take) begin
      for (int i = 0; i < sei_pkg::MAX_RESULTS - 1; i++) begin
        bytes[i] <= bytes[i+1];
      end
      bytes[sei_pkg::MAX_RESULTS-1] <= '0;
    end
  end

endmodule
